// File: rtl/core/alsfc_pkg.sv
// alsfc_pkg: shared widths, codes and constants of the lip-sync frame coder
package alsfc_pkg;

    // field widths
    localparam int SAMPLE_W = 16;
    localparam int MAG_W    = 16;
    localparam int ENERGY_W = 26;
    localparam int CODE_W   = 4;
    localparam int MOUTH_W  = 2;
    localparam int BROW_W   = 7;
    localparam int BLINK_W  = 6;

    // frame length limits
    localparam int MAX_FRAME_SAMPLES = 1024;
    localparam int CNT_W             = $clog2(MAX_FRAME_SAMPLES);
    localparam int LEN_W             = CNT_W + 1;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int SPF_W      = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_SPF    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEREO = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PASS   = 2'd2;

    localparam logic [SPF_W-1:0] SPF_RESET = 11'd735;

    // pass modes
    localparam logic PASS_MEASURE  = 1'b0;
    localparam logic PASS_GENERATE = 1'b1;

    // mouth levels
    localparam logic [MOUTH_W-1:0] MOUTH_CLOSED = 2'd0;
    localparam logic [MOUTH_W-1:0] MOUTH_HALF   = 2'd1;
    localparam logic [MOUTH_W-1:0] MOUTH_OPEN   = 2'd2;

    // brow counter and blink cycle
    localparam logic signed [BROW_W-1:0] BROW_RESET = BROW_W'(-30);
    localparam logic signed [BROW_W-1:0] BROW_WRAP  = BROW_W'(-50);
    localparam logic signed [BROW_W-1:0] BROW_LIMIT = BROW_W'(50);

    localparam logic [BLINK_W-1:0] BLINK_PERIOD    = BLINK_W'(45);
    localparam logic [BLINK_W-1:0] BLINK_ON_FRAMES = BLINK_W'(2);

    localparam logic [CODE_W-1:0] BROW_CODE_OFS  = CODE_W'(6);
    localparam logic [CODE_W-1:0] BLINK_CODE_OFS = CODE_W'(3);

    // x/5 as multiply by reciprocal, exact for 24-bit x
    localparam int RECIP_IN_W = ENERGY_W - 2;
    localparam int RECIP_W    = 32;
    localparam int RECIP_SH   = 34;
    localparam logic [RECIP_W-1:0] DIV5_RECIP = 32'hCCCC_CCCD;
    localparam int RECIP_PROD_W = RECIP_IN_W + RECIP_W;

    // energy scaled by 20 or 19 for the open test
    localparam int SCALED_W = ENERGY_W + 5;

    // control from the configuration registers
    typedef struct packed {
        logic pass_mode;
        logic clear_frame;
        logic clear_loudest;
    } alsfc_ctrl_t;

endpackage

// File: rtl/core/audio_lip_sync_frame_coder_core.sv
// audio_lip_sync_frame_coder_core: top level of the lip-sync frame coder
//
//   channel   direction  handshake           payload
//   in        input      in_valid/in_stall   left_sample, right_sample
//   out       output     out_valid/out_stall frame_code, mouth_level,
//                                            frame_energy, loudest_energy
//   cfg       input      cfg_write           cfg_index, cfg_data
//
// One sample item is taken per cycle while in_stall is low; three register stages
// (sample magnitude, frame accumulator, result) carry it. The divide by 20 of the
// loudest energy runs through one registered reciprocal multiply.
// Reset is asynchronous, active low, and loads the documented register values.
// A stalled result holds in the result register while samples keep entering;
// stall reaches the input only when a frame end meets full frame stages.
module audio_lip_sync_frame_coder_core (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [alsfc_pkg::SAMPLE_W-1:0]  left_sample,
    input  logic signed [alsfc_pkg::SAMPLE_W-1:0]  right_sample,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [alsfc_pkg::CODE_W-1:0]           frame_code,
    output logic [alsfc_pkg::MOUTH_W-1:0]          mouth_level,
    output logic [alsfc_pkg::ENERGY_W-1:0]         frame_energy,
    output logic [alsfc_pkg::ENERGY_W-1:0]         loudest_energy,
    input  logic                                   cfg_write,
    input  logic [alsfc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [alsfc_pkg::CFG_DATA_W-1:0]       cfg_data
);

    // configuration registers
    logic [alsfc_pkg::SPF_W-1:0]          spf_reg;
    logic                                 stereo_reg;
    logic                                 pass_reg;

    // sample stage
    logic                                 s1_valid_reg;
    logic [alsfc_pkg::MAG_W-1:0]          s1_mag_reg;

    logic signed [alsfc_pkg::SAMPLE_W:0]  pair_sum;
    logic signed [alsfc_pkg::SAMPLE_W:0]  sample_sel;
    logic [alsfc_pkg::SAMPLE_W:0]         sample_abs;
    logic                                 in_take;
    logic                                 mag_take;
    logic                                 pass_write;
    alsfc_pkg::alsfc_ctrl_t               ctrl;

    logic                                 frame_valid;
    logic [alsfc_pkg::ENERGY_W-1:0]       frame_sum;
    logic                                 frame_take;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spf_reg    <= alsfc_pkg::SPF_RESET;
            stereo_reg <= 1'b0;
            pass_reg   <= alsfc_pkg::PASS_MEASURE;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                alsfc_pkg::CFG_SPF:    spf_reg    <= cfg_data[alsfc_pkg::SPF_W-1:0];
                alsfc_pkg::CFG_STEREO: stereo_reg <= cfg_data[0];
                alsfc_pkg::CFG_PASS:   pass_reg   <= cfg_data[0];
                default:               ;
            endcase
        end
    end

    // pass write clears frame state, measure also clears loudest
    assign pass_write         = cfg_write && (cfg_index == alsfc_pkg::CFG_PASS);
    assign ctrl.pass_mode     = pass_reg;
    assign ctrl.clear_frame   = pass_write;
    assign ctrl.clear_loudest = pass_write && (cfg_data[0] == alsfc_pkg::PASS_MEASURE);

    // stereo average truncated toward zero, then magnitude
    always_comb
    begin
        pair_sum   = $signed({left_sample[alsfc_pkg::SAMPLE_W-1], left_sample})
                   + $signed({right_sample[alsfc_pkg::SAMPLE_W-1], right_sample});
        if (stereo_reg)
            sample_sel = (pair_sum + $signed({{alsfc_pkg::SAMPLE_W{1'b0}},
                                               pair_sum[alsfc_pkg::SAMPLE_W]})) >>> 1;
        else
            sample_sel = $signed({left_sample[alsfc_pkg::SAMPLE_W-1], left_sample});
        sample_abs = sample_sel[alsfc_pkg::SAMPLE_W] ? 17'(-sample_sel) : 17'(sample_sel);
    end

    // sample stage handshake
    assign in_stall = s1_valid_reg && !mag_take;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_take)
            s1_valid_reg <= 1'b1;
        else if (mag_take)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            s1_mag_reg <= sample_abs[alsfc_pkg::MAG_W-1:0];
    end

    // frame accumulation
    alsfc_accum u_accum (
        .clk               (clk),
        .rst_n             (rst_n),
        .ctrl              (ctrl),
        .samples_per_frame (spf_reg),
        .mag_valid         (s1_valid_reg),
        .mag               (s1_mag_reg),
        .mag_take          (mag_take),
        .frame_valid       (frame_valid),
        .frame_energy      (frame_sum),
        .frame_take        (frame_take)
    );

    // per-frame update and result register
    alsfc_frame_unit u_frame (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .frame_valid  (frame_valid),
        .frame_energy (frame_sum),
        .frame_take   (frame_take),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .frame_code   (frame_code),
        .mouth_level  (mouth_level),
        .energy_out   (frame_energy),
        .loudest_out  (loudest_energy)
    );

endmodule

// File: rtl/core/alsfc_accum.sv
// alsfc_accum: sample counter, frame energy accumulator and frame register
module alsfc_accum (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  alsfc_pkg::alsfc_ctrl_t               ctrl,
    input  logic [alsfc_pkg::SPF_W-1:0]          samples_per_frame,
    input  logic                                 mag_valid,
    input  logic [alsfc_pkg::MAG_W-1:0]          mag,
    output logic                                 mag_take,
    output logic                                 frame_valid,
    output logic [alsfc_pkg::ENERGY_W-1:0]       frame_energy,
    input  logic                                 frame_take
);

    logic [alsfc_pkg::CNT_W-1:0]    count_reg;
    logic [alsfc_pkg::ENERGY_W-1:0] acc_reg;
    logic                           fv_reg;
    logic [alsfc_pkg::ENERGY_W-1:0] fe_reg;

    logic [alsfc_pkg::LEN_W-1:0]    len_eff;
    logic [alsfc_pkg::LEN_W-1:0]    count_inc;
    logic [alsfc_pkg::ENERGY_W-1:0] acc_sum;
    logic                           frame_end;
    logic                           frame_ready;

    // effective frame length, zero acts as one, clamp at the maximum
    always_comb
    begin
        if (samples_per_frame == '0)
            len_eff = alsfc_pkg::LEN_W'(1);
        else if (32'(samples_per_frame) > alsfc_pkg::MAX_FRAME_SAMPLES)
            len_eff = alsfc_pkg::LEN_W'(alsfc_pkg::MAX_FRAME_SAMPLES);
        else
            len_eff = alsfc_pkg::LEN_W'(samples_per_frame);
    end

    // end of frame and accumulation
    assign count_inc   = {1'b0, count_reg} + alsfc_pkg::LEN_W'(1);
    assign frame_end   = (count_inc >= len_eff);
    assign acc_sum     = acc_reg + alsfc_pkg::ENERGY_W'(mag);
    assign frame_ready = !fv_reg || frame_take;
    assign mag_take    = mag_valid && (!frame_end || frame_ready);

    // counter and accumulator
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            acc_reg   <= '0;
        end
        else if (ctrl.clear_frame)
        begin
            count_reg <= '0;
            acc_reg   <= '0;
        end
        else if (mag_take)
        begin
            if (frame_end)
            begin
                count_reg <= '0;
                acc_reg   <= '0;
            end
            else
            begin
                count_reg <= count_inc[alsfc_pkg::CNT_W-1:0];
                acc_reg   <= acc_sum;
            end
        end
    end

    // frame item valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fv_reg <= 1'b0;
        else if (mag_take && frame_end)
            fv_reg <= 1'b1;
        else if (frame_take)
            fv_reg <= 1'b0;
    end

    // frame energy payload
    always_ff @(posedge clk)
    begin
        if (mag_take && frame_end)
            fe_reg <= acc_sum;
    end

    assign frame_valid  = fv_reg;
    assign frame_energy = fe_reg;

endmodule

// File: rtl/core/alsfc_frame_unit.sv
// alsfc_frame_unit: per-frame mouth, brow and blink update and result register
module alsfc_frame_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  alsfc_pkg::alsfc_ctrl_t               ctrl,
    input  logic                                 frame_valid,
    input  logic [alsfc_pkg::ENERGY_W-1:0]       frame_energy,
    output logic                                 frame_take,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [alsfc_pkg::CODE_W-1:0]         frame_code,
    output logic [alsfc_pkg::MOUTH_W-1:0]        mouth_level,
    output logic [alsfc_pkg::ENERGY_W-1:0]       energy_out,
    output logic [alsfc_pkg::ENERGY_W-1:0]       loudest_out
);

    // frame state
    logic [alsfc_pkg::ENERGY_W-1:0]       loudest_reg;
    logic [alsfc_pkg::ENERGY_W-1:0]       last_reg;
    logic [alsfc_pkg::ENERGY_W-1:0]       peak_reg;
    logic [alsfc_pkg::MOUTH_W-1:0]        mouth_reg;
    logic [alsfc_pkg::MOUTH_W-1:0]        shown_reg;
    logic signed [alsfc_pkg::BROW_W-1:0]  brow_reg;
    logic [alsfc_pkg::BLINK_W-1:0]        blink_reg;
    logic [alsfc_pkg::ENERGY_W-1:0]       delta_reg;

    // result register
    logic                                 ov_reg;
    logic [alsfc_pkg::CODE_W-1:0]         code_reg;
    logic [alsfc_pkg::MOUTH_W-1:0]        mouth_out_reg;
    logic [alsfc_pkg::ENERGY_W-1:0]       energy_reg;
    logic [alsfc_pkg::ENERGY_W-1:0]       loud_out_reg;

    // next values
    logic [alsfc_pkg::ENERGY_W-1:0]       loudest_next;
    logic [alsfc_pkg::ENERGY_W-1:0]       peak_next;
    logic [alsfc_pkg::MOUTH_W-1:0]        mouth_next;
    logic [alsfc_pkg::MOUTH_W-1:0]        shown_next;
    logic signed [alsfc_pkg::BROW_W-1:0]  brow_next;
    logic [alsfc_pkg::BLINK_W-1:0]        blink_next;
    logic [alsfc_pkg::CODE_W-1:0]         code_next;
    logic [alsfc_pkg::ENERGY_W-1:0]       delta_next;

    // intermediates
    logic [alsfc_pkg::RECIP_PROD_W-1:0]   recip_prod;
    logic [alsfc_pkg::ENERGY_W-1:0]       low;
    logic [alsfc_pkg::ENERGY_W:0]         last_plus;
    logic [alsfc_pkg::MOUTH_W-1:0]        m_rise;
    logic [alsfc_pkg::MOUTH_W-1:0]        m_open;
    logic [alsfc_pkg::MOUTH_W-1:0]        m_close;
    logic [alsfc_pkg::ENERGY_W-1:0]       pk_max;
    logic [alsfc_pkg::SCALED_W-1:0]       tot20;
    logic [alsfc_pkg::SCALED_W-1:0]       pk19;
    logic signed [alsfc_pkg::BROW_W-1:0]  brow_sum;
    logic [alsfc_pkg::BLINK_W-1:0]        blink_inc;
    logic                                 blink;
    logic                                 out_ready;

    // delta = loudest / 20 as (loudest / 4) / 5, registered after the multiply
    assign recip_prod = alsfc_pkg::RECIP_PROD_W'(loudest_reg[alsfc_pkg::ENERGY_W-1:2]) *
                        alsfc_pkg::RECIP_PROD_W'(alsfc_pkg::DIV5_RECIP);
    assign delta_next = alsfc_pkg::ENERGY_W'(
                            recip_prod[alsfc_pkg::RECIP_PROD_W-1:alsfc_pkg::RECIP_SH]);
    assign low        = loudest_reg >> 2;

    // handshake
    assign out_ready  = !ov_reg || !out_stall;
    assign frame_take = frame_valid && out_ready;

    // mouth state update
    always_comb
    begin
        last_plus = {1'b0, last_reg} + {1'b0, delta_reg};
        m_rise    = ({1'b0, frame_energy} > last_plus) ? alsfc_pkg::MOUTH_HALF : mouth_reg;
        pk_max    = (m_rise == alsfc_pkg::MOUTH_HALF && frame_energy > peak_reg)
                    ? frame_energy : peak_reg;
        tot20     = (alsfc_pkg::SCALED_W'(frame_energy) << 4)
                    + (alsfc_pkg::SCALED_W'(frame_energy) << 2);
        pk19      = (alsfc_pkg::SCALED_W'(pk_max) << 4)
                    + (alsfc_pkg::SCALED_W'(pk_max) << 1)
                    + alsfc_pkg::SCALED_W'(pk_max);
        m_open    = (m_rise == alsfc_pkg::MOUTH_HALF && tot20 > pk19)
                    ? alsfc_pkg::MOUTH_OPEN : m_rise;
        if (frame_energy < (pk_max >> 1))
        begin
            m_close   = alsfc_pkg::MOUTH_CLOSED;
            peak_next = '0;
        end
        else
        begin
            m_close   = m_open;
            peak_next = pk_max;
        end
        mouth_next = (frame_energy < low && m_close == alsfc_pkg::MOUTH_OPEN)
                     ? alsfc_pkg::MOUTH_HALF : m_close;
    end

    // display smoothing, brow, blink and frame code
    always_comb
    begin
        if (mouth_next == alsfc_pkg::MOUTH_CLOSED && shown_reg == alsfc_pkg::MOUTH_OPEN)
            shown_next = alsfc_pkg::MOUTH_HALF;
        else if (mouth_next == alsfc_pkg::MOUTH_OPEN && shown_reg == alsfc_pkg::MOUTH_CLOSED)
            shown_next = alsfc_pkg::MOUTH_HALF;
        else
            shown_next = mouth_next;

        brow_sum  = brow_reg + $signed({{(alsfc_pkg::BROW_W - alsfc_pkg::MOUTH_W){1'b0}},
                                        shown_next});
        brow_next = (brow_sum > alsfc_pkg::BROW_LIMIT) ? alsfc_pkg::BROW_WRAP : brow_sum;

        blink      = (blink_reg < alsfc_pkg::BLINK_ON_FRAMES);
        blink_inc  = blink_reg + alsfc_pkg::BLINK_W'(1);
        blink_next = (blink_inc >= alsfc_pkg::BLINK_PERIOD) ? '0 : blink_inc;

        code_next = alsfc_pkg::CODE_W'(shown_next)
                    + ((brow_next != '0) ? alsfc_pkg::BROW_CODE_OFS : '0)
                    + (blink ? alsfc_pkg::BLINK_CODE_OFS : '0);
    end

    // loudest frame in measure pass
    assign loudest_next = (frame_energy > loudest_reg) ? frame_energy : loudest_reg;

    // divider register
    always_ff @(posedge clk)
    begin
        delta_reg <= delta_next;
    end

    // loudest register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            loudest_reg <= '0;
        else if (ctrl.clear_loudest)
            loudest_reg <= '0;
        else if (frame_take && ctrl.pass_mode == alsfc_pkg::PASS_MEASURE)
            loudest_reg <= loudest_next;
    end

    // generate-pass frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg  <= '0;
            peak_reg  <= '0;
            mouth_reg <= alsfc_pkg::MOUTH_CLOSED;
            shown_reg <= alsfc_pkg::MOUTH_CLOSED;
            brow_reg  <= alsfc_pkg::BROW_RESET;
            blink_reg <= '0;
        end
        else if (ctrl.clear_frame)
        begin
            last_reg  <= '0;
            peak_reg  <= '0;
            mouth_reg <= alsfc_pkg::MOUTH_CLOSED;
            shown_reg <= alsfc_pkg::MOUTH_CLOSED;
            brow_reg  <= alsfc_pkg::BROW_RESET;
            blink_reg <= '0;
        end
        else if (frame_take && ctrl.pass_mode == alsfc_pkg::PASS_GENERATE)
        begin
            last_reg  <= frame_energy;
            peak_reg  <= peak_next;
            mouth_reg <= mouth_next;
            shown_reg <= shown_next;
            brow_reg  <= brow_next;
            blink_reg <= blink_next;
        end
    end

    // result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (frame_take)
            ov_reg <= 1'b1;
        else if (!out_stall)
            ov_reg <= 1'b0;
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (frame_take)
        begin
            energy_reg <= frame_energy;
            if (ctrl.pass_mode == alsfc_pkg::PASS_MEASURE)
            begin
                code_reg      <= '0;
                mouth_out_reg <= alsfc_pkg::MOUTH_CLOSED;
                loud_out_reg  <= loudest_next;
            end
            else
            begin
                code_reg      <= code_next;
                mouth_out_reg <= shown_next;
                loud_out_reg  <= loudest_reg;
            end
        end
    end

    assign out_valid   = ov_reg;
    assign frame_code  = code_reg;
    assign mouth_level = mouth_out_reg;
    assign energy_out  = energy_reg;
    assign loudest_out = loud_out_reg;

endmodule
